// File: hdl/hbd_pkg.sv
`timescale 1ns / 1ps

package hbd_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int BODY_LEN_W  = 32;
  localparam int USER_W      = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKED_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_LENGTH  = 1'b1;

  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;

  // Bit positions inside the output tuser.
  localparam int USER_PAYLOAD_VALID = 0;
  localparam int USER_MESSAGE_DONE  = 1;
  localparam int USER_FORMAT_ERROR  = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              payload_valid;
    logic              chunk_last;
    logic              message_done;
    logic              format_error;
  } result_t;

endpackage

// File: hdl/hbd_core.sv
`timescale 1ns / 1ps

module hbd_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           restart,
  input  logic [hbd_pkg::BODY_LEN_W-1:0] restart_len,
  input  logic                           chunked_mode,
  input  logic                           step,
  input  logic [hbd_pkg::BYTE_W-1:0]     data_byte,
  output hbd_pkg::result_t               result
);
  import hbd_pkg::*;

  localparam int CNT_W = (SIZE_BITS > BODY_LEN_W) ? SIZE_BITS : BODY_LEN_W;

  typedef enum logic [2:0] {
    PH_SIZE_START,
    PH_SIZE_DIGITS,
    PH_SIZE_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF
  } phase_t;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  logic [CNT_W-1:0]     bytes_left, bytes_left_next;
  logic                 in_extension, in_extension_next;
  logic                 seen_zero_chunk, seen_zero_chunk_next;
  logic                 done_flag, done_flag_next;
  logic                 error_flag, error_flag_next;

  logic                 hex_ok;
  logic [3:0]           hex_val;
  logic                 size_full;
  logic                 valid;
  logic                 last;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, 4'(b - "0")};
    end else if (b >= "a" && b <= "f") begin
      r = {1'b1, 4'(b - "a" + 8'd10)};
    end else if (b >= "A" && b <= "F") begin
      r = {1'b1, 4'(b - "A" + 8'd10)};
    end
    return r;
  endfunction

  assign {hex_ok, hex_val} = hex_decode(data_byte);
  // Another digit would shift a nonzero nibble out of the size.
  assign size_full = |size_accum[SIZE_BITS-1:SIZE_BITS-4];

  always_comb begin
    phase_next           = phase;
    size_accum_next      = size_accum;
    bytes_left_next      = bytes_left;
    in_extension_next    = in_extension;
    seen_zero_chunk_next = seen_zero_chunk;
    done_flag_next       = done_flag;
    error_flag_next      = error_flag;
    valid                = 1'b0;
    last                 = 1'b0;

    if (!error_flag && !done_flag) begin
      if (!chunked_mode) begin
        if (bytes_left == '0) begin
          done_flag_next = 1'b1;
        end else begin
          valid           = 1'b1;
          bytes_left_next = bytes_left - CNT_W'(1);
          if (bytes_left == CNT_W'(1)) begin
            last           = 1'b1;
            done_flag_next = 1'b1;
          end
        end
      end else begin
        unique case (phase)
          PH_SIZE_START: begin
            if (!hex_ok || size_full) begin
              error_flag_next = 1'b1;
            end else begin
              size_accum_next = {size_accum[SIZE_BITS-5:0], hex_val};
              phase_next      = PH_SIZE_DIGITS;
            end
          end
          PH_SIZE_DIGITS: begin
            if (data_byte == BYTE_CR) begin
              phase_next = PH_SIZE_LF;
            end else if (data_byte == BYTE_LF) begin
              error_flag_next = 1'b1;
            end else if (!in_extension && hex_ok) begin
              if (size_full) begin
                error_flag_next = 1'b1;
              end else begin
                size_accum_next = {size_accum[SIZE_BITS-5:0], hex_val};
              end
            end else begin
              in_extension_next = 1'b1;
            end
          end
          PH_SIZE_LF: begin
            if (data_byte != BYTE_LF) begin
              error_flag_next = 1'b1;
            end else if (size_accum == '0) begin
              seen_zero_chunk_next = 1'b1;
              phase_next           = PH_DATA_CR;
            end else begin
              bytes_left_next = CNT_W'(size_accum);
              phase_next      = PH_DATA;
            end
          end
          PH_DATA: begin
            valid = 1'b1;
            if (bytes_left != '0) begin
              bytes_left_next = bytes_left - CNT_W'(1);
            end
            if (bytes_left <= CNT_W'(1)) begin
              last       = 1'b1;
              phase_next = PH_DATA_CR;
            end
          end
          PH_DATA_CR: begin
            if (data_byte == BYTE_CR) begin
              phase_next = PH_DATA_LF;
            end else begin
              error_flag_next = 1'b1;
            end
          end
          PH_DATA_LF: begin
            if (data_byte != BYTE_LF) begin
              error_flag_next = 1'b1;
            end else if (seen_zero_chunk) begin
              done_flag_next = 1'b1;
            end else begin
              phase_next        = PH_SIZE_START;
              size_accum_next   = '0;
              in_extension_next = 1'b0;
            end
          end
          default: begin
            error_flag_next = 1'b1;
          end
        endcase
      end
    end

    result.out_byte      = valid ? data_byte : '0;
    result.payload_valid = valid;
    result.chunk_last    = last;
    result.message_done  = done_flag_next;
    result.format_error  = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE_START;
      size_accum      <= '0;
      bytes_left      <= '0;
      in_extension    <= 1'b0;
      seen_zero_chunk <= 1'b0;
      done_flag       <= 1'b0;
      error_flag      <= 1'b0;
    end else if (restart) begin
      phase           <= PH_SIZE_START;
      size_accum      <= '0;
      bytes_left      <= CNT_W'(restart_len);
      in_extension    <= 1'b0;
      seen_zero_chunk <= 1'b0;
      done_flag       <= 1'b0;
      error_flag      <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      size_accum      <= size_accum_next;
      bytes_left      <= bytes_left_next;
      in_extension    <= in_extension_next;
      seen_zero_chunk <= seen_zero_chunk_next;
      done_flag       <= done_flag_next;
      error_flag      <= error_flag_next;
    end
  end

endmodule

// File: hdl/http_body_deframer.sv
`timescale 1ns / 1ps
// An accepted word passes through the input register, then the result register.
// Throughput: one word per cycle unless the output stalls; the input and result registers
// each hold one word, so a new word is taken while a finished one waits downstream.
// Reset (rst, synchronous): both registers empty, chunked_mode and body_length zero,
// the decoder at the start of a size line. Any register write restarts the decoder.
module http_body_deframer #(
  parameter int SIZE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] in_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] out_byte
  output logic                           m_axis_tlast,  // chunk_last
  // [0] payload_valid, [1] message_done, [2] format_error
  output logic [hbd_pkg::USER_W-1:0]     m_axis_tuser,
  input  logic                           cfg_wen,
  input  logic [hbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hbd_pkg::*;

  logic                  chunked_mode;
  logic [BODY_LEN_W-1:0] body_length;
  logic [BODY_LEN_W-1:0] restart_len;

  logic                  in_valid;
  logic [BYTE_W-1:0]     in_byte;
  logic                  out_valid;
  result_t               out_result;
  result_t               step_result;

  logic                  advance;
  logic                  in_accept;
  logic                  step;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign step          = in_valid && advance;

  assign restart_len = (cfg_index == REG_BODY_LENGTH) ? BODY_LEN_W'(cfg_wdata) : body_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode <= 1'b0;
      body_length  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_CHUNKED_MODE: chunked_mode <= cfg_wdata[0];
        REG_BODY_LENGTH:  body_length  <= BODY_LEN_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid <= in_accept || (in_valid && !advance);
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte <= s_axis_tdata;
    end
    if (step) begin
      out_result <= step_result;
    end
  end

  hbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_wen),
    .restart_len (restart_len),
    .chunked_mode(chunked_mode),
    .step        (step),
    .data_byte   (in_byte),
    .result      (step_result)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result.out_byte;
  assign m_axis_tlast  = out_result.chunk_last;
  assign m_axis_tuser[USER_PAYLOAD_VALID] = out_result.payload_valid;
  assign m_axis_tuser[USER_MESSAGE_DONE]  = out_result.message_done;
  assign m_axis_tuser[USER_FORMAT_ERROR]  = out_result.format_error;

  // A held input word must not be lost or replaced while the output stalls.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("input word dropped while output stalled");

  // Only payload words can close a chunk.
  a_last_is_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[USER_PAYLOAD_VALID])
    else $error("chunk_last on a non-payload word");

  // Framing errors never occur on a payload word.
  a_error_not_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[USER_FORMAT_ERROR] |-> !m_axis_tuser[USER_PAYLOAD_VALID])
    else $error("payload passed after a framing error");

endmodule
